### rtl/upc_pkg.sv
// Shared types, header offsets and ones-complement helpers for the
// UDP pseudoheader checksum block. No dependencies.
package upc_pkg;

    // One packet byte with its side information
    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] ip_offset;
        logic       is_ipv6;
        logic       last_byte;
    } t_item;

    // Result of one packet
    typedef struct packed {
        logic [15:0] udp_checksum;
        logic        truncated;
    } t_result;

    // Offsets inside the IP header, relative to its first byte
    localparam logic [15:0] REL_IP_FIRST     = 16'd0;
    localparam logic [15:0] V4_TOTLEN_HI     = 16'd2;
    localparam logic [15:0] V4_TOTLEN_LO     = 16'd3;
    localparam logic [15:0] V4_PROTOCOL      = 16'd9;
    localparam logic [15:0] V4_ADDR_FIRST    = 16'd12;
    localparam logic [15:0] V4_ADDR_LAST     = 16'd19;
    localparam logic [15:0] V6_PLEN_HI       = 16'd4;
    localparam logic [15:0] V6_PLEN_LO       = 16'd5;
    localparam logic [15:0] V6_NEXT_HDR      = 16'd6;
    localparam logic [15:0] V6_ADDR_FIRST    = 16'd8;
    localparam logic [15:0] V6_ADDR_LAST     = 16'd39;
    localparam logic [5:0]  IPV6_HDR_BYTES   = 6'd40;

    // Offsets inside the UDP header
    localparam logic [15:0] UDP_SPORT_HI     = 16'd0;
    localparam logic [15:0] UDP_SPORT_LO     = 16'd1;
    localparam logic [15:0] UDP_DPORT_HI     = 16'd2;
    localparam logic [15:0] UDP_DPORT_LO     = 16'd3;
    localparam logic [15:0] UDP_LEN_HI       = 16'd4;
    localparam logic [15:0] UDP_LEN_LO       = 16'd5;
    localparam logic [15:0] UDP_HDR_BYTES    = 16'd6;
    localparam logic [15:0] UDP_DATA_FIRST   = 16'd8;

    localparam logic [15:0] COUNT_MAX        = 16'hFFFF;

    // Byte placed in its 16-bit word: even position is the high half
    function automatic logic [15:0] byte_word(input logic odd_pos, input logic [7:0] b);
        byte_word = odd_pos ? {8'h00, b} : {b, 8'h00};
    endfunction

    // End-around carry fold of a sum of up to eight 16-bit words
    function automatic logic [15:0] fold19(input logic [18:0] s);
        logic [16:0] t1;
        logic [16:0] t2;
        t1 = {14'd0, s[18:16]} + {1'b0, s[15:0]};
        t2 = {16'd0, t1[16]} + {1'b0, t1[15:0]};
        fold19 = t2[15:0];
    endfunction

endpackage

### rtl/udp_pseudoheader_checksum_unit.sv
// Top level of the UDP pseudoheader checksum block: input and result
// registers with valid/stall handshakes. Depends on upc_pkg and upc_core.
//
// Usage:
//   Input channel (i_valid / o_stall): one packet byte per transfer, with
//   i_ip_offset and i_is_ipv6 held for the packet and i_last_byte on the
//   final byte. Bytes before the IP offset are skipped.
//   Output channel (o_valid / i_stall): one transfer per packet, on its
//   last byte: o_udp_checksum is the inverted folded ones-complement sum
//   over the pseudoheader, UDP header (checksum field as zero) and UDP
//   payload; o_truncated flags a packet that ended before its UDP length or
//   before its UDP length field. A truncated packet reports checksum zero.
// Path: a transferred byte waits in the input register and is processed as
//   it advances; for a last byte the result is captured in the result
//   register at that step.
// Throughput: one byte per cycle unless the input is stalled, with all
//   words of a byte summed in one add in the core; the result register lets
//   the next packet start while a result waits.
// Stall: a stalled result holds; a last byte waiting behind it stalls the
//   input, other bytes keep flowing.
// Reset: synchronous, active low; clears the valid flags of both
//   registers and all packet state.
module udp_pseudoheader_checksum_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_ip_offset,
    input  logic        i_is_ipv6,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_udp_checksum,
    output logic        o_truncated
);
    import upc_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result core_result;
    logic    advance;
    logic    in_take;

    // A byte moves on unless it is a last byte and the result slot is blocked
    assign advance = r_in_valid && (!r_in.last_byte || !r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.data_byte <= i_data_byte;
            r_in.ip_offset <= i_ip_offset;
            r_in.is_ipv6   <= i_is_ipv6;
            r_in.last_byte <= i_last_byte;
        end
    end

    upc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in),
        .o_result (core_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in.last_byte) begin
            r_out <= core_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_udp_checksum = r_out.udp_checksum;
    assign o_truncated    = r_out.truncated;

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.last_byte |=> r_out_valid)
        else $error("last byte processed without a result");

    a_held_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in))
        else $error("held input byte lost or changed");

    a_trunc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.truncated |-> r_out.udp_checksum == 16'h0000)
        else $error("truncated packet with nonzero checksum");

endmodule

### rtl/upc_core.sv
// Per-packet state and one-byte checksum step for the UDP pseudoheader
// checksum block. Depends on upc_pkg.
module upc_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  upc_pkg::t_item  i_item,
    output upc_pkg::t_result o_result
);
    import upc_pkg::*;

    logic [15:0] r_byte_index, n_byte_index;
    logic [15:0] r_sum, n_sum;
    logic [5:0]  r_ihb, n_ihb;
    logic [15:0] r_ulen, n_ulen;
    logic [15:0] r_iplen, n_iplen;
    logic [15:0] r_ubs, n_ubs;
    logic [31:0] r_head, n_head;

    logic        idx_sat;
    logic        active;
    logic [15:0] rel;
    logic [15:0] ip_word;
    logic [15:0] iplen_full;
    logic        udp_take;
    logic [15:0] ulen_new;
    logic [15:0] u0_word, u1_word, u2_word;
    logic [18:0] sum_wide;
    logic [7:0]  b;
    logic        trunc;

    assign b          = i_item.data_byte;
    assign idx_sat    = (r_byte_index == COUNT_MAX);
    assign active     = !idx_sat && (r_byte_index >= {8'h00, i_item.ip_offset});
    assign rel        = r_byte_index - {8'h00, i_item.ip_offset};
    assign iplen_full = {r_iplen[15:8], b};
    assign ulen_new   = {r_ulen[15:8], b};

    // IP header: pseudoheader fields and header length
    always_comb begin
        n_ihb   = r_ihb;
        n_iplen = r_iplen;
        ip_word = 16'h0000;
        if (active) begin
            if (i_item.is_ipv6) begin
                if (rel == REL_IP_FIRST) n_ihb = IPV6_HDR_BYTES;
                if (rel == V6_PLEN_HI) n_iplen = {b, 8'h00};
                if (rel == V6_PLEN_LO) begin
                    n_iplen = iplen_full;
                    ip_word = iplen_full;
                end
                if (rel == V6_NEXT_HDR) ip_word = {8'h00, b};
                if (rel >= V6_ADDR_FIRST && rel <= V6_ADDR_LAST) ip_word = byte_word(rel[0], b);
            end else begin
                if (rel == REL_IP_FIRST) n_ihb = {b[3:0], 2'b00};
                if (rel == V4_TOTLEN_HI) n_iplen = {b, 8'h00};
                if (rel == V4_TOTLEN_LO) begin
                    n_iplen = iplen_full;
                    ip_word = iplen_full - {10'd0, r_ihb};
                end
                if (rel == V4_PROTOCOL) ip_word = {8'h00, b};
                if (rel >= V4_ADDR_FIRST && rel <= V4_ADDR_LAST) ip_word = byte_word(rel[0], b);
            end
        end
    end

    // UDP header and payload; header words go in once the length is known
    assign udp_take = active && (rel >= {10'd0, n_ihb});

    always_comb begin
        n_ulen  = r_ulen;
        n_head  = r_head;
        n_ubs   = r_ubs;
        u0_word = 16'h0000;
        u1_word = 16'h0000;
        u2_word = 16'h0000;
        if (udp_take) begin
            if (r_ubs < UDP_LEN_HI) begin
                case (r_ubs[1:0])
                    2'd0:    n_head[31:24] = b;
                    2'd1:    n_head[23:16] = b;
                    2'd2:    n_head[15:8]  = b;
                    default: n_head[7:0]   = b;
                endcase
            end else if (r_ubs == UDP_LEN_HI) begin
                n_ulen = {b, 8'h00};
            end else if (r_ubs == UDP_LEN_LO) begin
                n_ulen  = ulen_new;
                u0_word = {(ulen_new > UDP_SPORT_HI) ? r_head[31:24] : 8'h00,
                           (ulen_new > UDP_SPORT_LO) ? r_head[23:16] : 8'h00};
                u1_word = {(ulen_new > UDP_DPORT_HI) ? r_head[15:8] : 8'h00,
                           (ulen_new > UDP_DPORT_LO) ? r_head[7:0] : 8'h00};
                u2_word = {(ulen_new > UDP_LEN_HI) ? r_ulen[15:8] : 8'h00,
                           (ulen_new > UDP_LEN_LO) ? b : 8'h00};
            end else if (r_ubs >= UDP_DATA_FIRST && r_ubs < r_ulen) begin
                u0_word = byte_word(r_ubs[0], b);
            end
            if (r_ubs != COUNT_MAX) n_ubs = r_ubs + 16'd1;
        end
    end

    // Accumulate all words of this byte in one add, then fold
    assign sum_wide = {3'b000, r_sum} + {3'b000, ip_word} + {3'b000, u0_word}
                    + {3'b000, u1_word} + {3'b000, u2_word};
    assign n_sum        = fold19(sum_wide);
    assign n_byte_index = idx_sat ? r_byte_index : r_byte_index + 16'd1;

    // Result as of the state after this byte
    assign trunc                 = (n_ubs < UDP_HDR_BYTES) || (n_ubs < n_ulen);
    assign o_result.truncated    = trunc;
    assign o_result.udp_checksum = trunc ? 16'h0000 : ~n_sum;

    // Packet state; cleared after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last_byte)) begin
            r_byte_index <= '0;
            r_sum        <= '0;
            r_ihb        <= '0;
            r_ulen       <= '0;
            r_iplen      <= '0;
            r_ubs        <= '0;
            r_head       <= '0;
        end else if (i_step) begin
            r_byte_index <= n_byte_index;
            r_sum        <= n_sum;
            r_ihb        <= n_ihb;
            r_ulen       <= n_ulen;
            r_iplen      <= n_iplen;
            r_ubs        <= n_ubs;
            r_head       <= n_head;
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.last_byte |=> r_byte_index == '0 && r_sum == '0 && r_ubs == '0)
        else $error("packet state not cleared after last byte");

    a_fresh_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_index == '0 |-> r_ubs == '0 && r_sum == '0 && r_ulen == '0)
        else $error("UDP state present before any byte of the packet");

    a_sum_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_sum) && $stable(r_byte_index))
        else $error("sum changed without a byte step");

endmodule
